>>> rtl/avn_pkg.sv
// ----------------------------------------------------------------------------
// avn_pkg
// Shared types and constants of the vertex normal averaging block.
// ----------------------------------------------------------------------------
package avn_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int FRAC_BITS_DEF    = 16;

	localparam int IDX_W       = 10;
	localparam int DATA_W      = 32;
	localparam int OUT_W       = 18;
	localparam int S_TDATA_W   = 224;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 56;
	localparam int M_TUSER_W   = 1;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_TRI  = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_TRI,
		OP_READ
	} avn_op_t;

	typedef struct packed {
		avn_op_t                  op;
		logic [IDX_W-1:0]         idx_a;
		logic [IDX_W-1:0]         idx_b;
		logic [IDX_W-1:0]         idx_c;
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] init_nx;
		logic signed [DATA_W-1:0] init_ny;
		logic signed [DATA_W-1:0] init_nz;
	} avn_item_t;

	typedef struct packed {
		logic done;
		logic zero;
	} avn_nstat_t;

endpackage

>>> rtl/avn_ram.sv
// ----------------------------------------------------------------------------
// avn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module avn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/avn_norm.sv
// ----------------------------------------------------------------------------
// avn_norm
// Iterative unit that scales a 3-vector to unit length in fixed point.
// ----------------------------------------------------------------------------
module avn_norm #(
	parameter int FRAC_BITS = avn_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [63:0]         vin [3],
	output logic signed [FRAC_BITS+1:0] u [3],
	output avn_pkg::avn_nstat_t        stat
);

	typedef enum logic [2:0] {
		N_IDLE,
		N_CHECK,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DSET,
		N_DIV,
		N_DONE
	} state_t;

	state_t               state_q;
	logic [4:0]           cnt_q;
	logic                 zero_q;
	logic                 neg_q  [3];
	logic [62:0]          mag_q  [3];
	logic [61:0]          acc_q;
	logic [30:0]          root_q;
	logic [32:0]          rem_q;
	logic [31:0]          drem_q [3];
	logic [FRAC_BITS:0]   num_q  [3];
	logic [FRAC_BITS:0]   quo_q  [3];

	logic [62:0]          mx;
	logic [59:0]          sq;
	logic [34:0]          rem_n;
	logic [34:0]          trial;
	logic [FRAC_BITS+30:0] dnum  [3];
	logic [32:0]          dtry  [3];

	always_comb begin
		mx = mag_q[0];
		if (mag_q[1] > mx) begin
			mx = mag_q[1];
		end
		if (mag_q[2] > mx) begin
			mx = mag_q[2];
		end
		sq    = mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0];
		rem_n = {rem_q, acc_q[61:60]};
		trial = {2'b00, root_q, 2'b01};
		for (int i = 0; i < 3; i++) begin
			dnum[i] = {1'b0, mag_q[i][29:0], {FRAC_BITS{1'b0}}}
				+ (FRAC_BITS+31)'(root_q[30:1]);
			dtry[i] = {drem_q[i], num_q[i][FRAC_BITS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			cnt_q   <= '0;
			zero_q  <= 1'b0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int i = 0; i < 3; i++) begin
							neg_q[i] <= vin[i][63];
							mag_q[i] <= vin[i][63] ? 63'(-vin[i]) : vin[i][62:0];
						end
						state_q <= N_CHECK;
					end
				end
				N_CHECK: begin
					if (mx == '0) begin
						zero_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							quo_q[i] <= '0;
						end
						state_q <= N_DONE;
					end else begin
						zero_q  <= 1'b0;
						state_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (mx[62:38] != '0) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 8;
					end else if (mx[62:30] != '0) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (mx[29]) begin
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= N_SQ;
					end else if (mx[29:21] == '0) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 8;
					end else begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end
				end
				N_SQ: begin
					acc_q <= acc_q + 62'(sq);
					if (cnt_q == 5'd2) begin
						cnt_q   <= 5'd30;
						root_q  <= '0;
						rem_q   <= '0;
						state_q <= N_SQRT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				N_SQRT: begin
					acc_q <= acc_q << 2;
					if (rem_n >= trial) begin
						rem_q  <= 33'(rem_n - trial);
						root_q <= {root_q[29:0], 1'b1};
					end else begin
						rem_q  <= rem_n[32:0];
						root_q <= {root_q[29:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= N_DSET;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				N_DSET: begin
					for (int i = 0; i < 3; i++) begin
						drem_q[i] <= 32'(dnum[i] >> (FRAC_BITS+1));
						num_q[i]  <= dnum[i][FRAC_BITS:0];
						quo_q[i]  <= '0;
					end
					cnt_q   <= 5'(FRAC_BITS);
					state_q <= N_DIV;
				end
				N_DIV: begin
					for (int i = 0; i < 3; i++) begin
						num_q[i] <= num_q[i] << 1;
						if (dtry[i] >= {2'b00, root_q}) begin
							drem_q[i] <= 32'(dtry[i] - {2'b00, root_q});
							quo_q[i]  <= {quo_q[i][FRAC_BITS-1:0], 1'b1};
						end else begin
							drem_q[i] <= dtry[i][31:0];
							quo_q[i]  <= {quo_q[i][FRAC_BITS-1:0], 1'b0};
						end
					end
					if (cnt_q == '0) begin
						state_q <= N_DONE;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u[i] = neg_q[i] ? -$signed({1'b0, quo_q[i]}) : $signed({1'b0, quo_q[i]});
		end
		stat.done = (state_q == N_DONE);
		stat.zero = zero_q;
	end

endmodule

>>> rtl/avn_front.sv
// ----------------------------------------------------------------------------
// avn_front
// Input side: accepts items, decodes their kind and queues those of a known kind.
// ----------------------------------------------------------------------------
module avn_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [avn_pkg::S_TDATA_W-1:0]     s_tdata,
	input  logic [avn_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                              q_valid,
	output avn_pkg::avn_item_t                q_item,
	input  logic                              q_pop
);

	avn_pkg::avn_item_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	avn_pkg::avn_item_t item;
	logic               keep;
	logic               push;

	always_comb begin
		item.idx_a   = s_tdata[9:0];
		item.idx_b   = s_tdata[19:10];
		item.idx_c   = s_tdata[29:20];
		item.pos_x   = s_tdata[61:30];
		item.pos_y   = s_tdata[93:62];
		item.pos_z   = s_tdata[125:94];
		item.init_nx = s_tdata[157:126];
		item.init_ny = s_tdata[189:158];
		item.init_nz = s_tdata[221:190];
		keep         = 1'b1;
		unique case (s_tuser)
			avn_pkg::FUNC_LOAD: item.op = avn_pkg::OP_LOAD;
			avn_pkg::FUNC_TRI:  item.op = avn_pkg::OP_TRI;
			avn_pkg::FUNC_READ: item.op = avn_pkg::OP_READ;
			default: begin
				item.op = avn_pkg::OP_LOAD;
				keep    = 1'b0;
			end
		endcase
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready && keep;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

>>> rtl/avn_back.sv
// ----------------------------------------------------------------------------
// avn_back
// Execution side: vertex memories, cross product and normal accumulation.
// ----------------------------------------------------------------------------
module avn_back #(
	parameter int MAX_VERTICES = avn_pkg::MAX_VERTICES_DEF,
	parameter int FRAC_BITS    = avn_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  avn_pkg::avn_item_t            q_item,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [avn_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [avn_pkg::M_TUSER_W-1:0] m_tuser
);

	localparam int IW    = $clog2(MAX_VERTICES);
	localparam int RECIP = (1 << 20) / MAX_VERTICES;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MOD1,
		S_MOD2,
		S_LOAD,
		S_RD,
		S_RD_WAIT,
		S_NWAIT_RD,
		S_OUT,
		S_RA,
		S_RB,
		S_RC,
		S_EDGE,
		S_MUL,
		S_CROSS,
		S_NWAIT_TRI,
		S_URD,
		S_UWR
	} state_t;

	state_t                state_q;
	avn_pkg::avn_item_t    item_q;
	logic [9:0]            raw     [3];
	logic [9:0]            qest_q  [3];
	logic [IW-1:0]         idx_q   [3];
	logic [2:0]            cnt_q;
	logic [1:0]            k_q;
	logic [95:0]           pa_q;
	logic [95:0]           pb_q;
	logic signed [31:0]    e1_q    [3];
	logic signed [31:0]    e2_q    [3];
	logic signed [63:0]    prod_q  [6];
	logic                  m_tvalid_q;
	logic [avn_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	logic                  pos_we;
	logic [IW-1:0]         pos_raddr;
	logic [95:0]           pos_rdata;
	logic                  nrm_we;
	logic [IW-1:0]         nrm_waddr;
	logic [95:0]           nrm_wdata;
	logic [IW-1:0]         nrm_raddr;
	logic [95:0]           nrm_rdata;

	logic                  norm_start;
	logic signed [63:0]    vin     [3];
	logic signed [FRAC_BITS+1:0] u [3];
	avn_pkg::avn_nstat_t   nstat;

	logic [30:0]           qt      [3];
	logic [26:0]           qm      [3];
	logic [9:0]            rr      [3];
	logic [9:0]            rm      [3];
	logic signed [31:0]    mul_a;
	logic signed [31:0]    mul_b;
	logic signed [63:0]    mul_p;
	logic signed [32:0]    d1      [3];
	logic signed [32:0]    d2      [3];
	logic signed [32:0]    h1      [3];
	logic signed [32:0]    h2      [3];
	logic signed [31:0]    pc      [3];
	logic signed [31:0]    pa      [3];
	logic signed [31:0]    pb      [3];
	logic signed [31:0]    sum_in  [3];
	logic signed [33:0]    sum_ext [3];
	logic signed [31:0]    sum_sat [3];
	logic                  out_free;

	function automatic logic [avn_pkg::OUT_W-1:0] OUT_18(input logic signed [FRAC_BITS+1:0] v);
		OUT_18 = avn_pkg::OUT_W'(v);
	endfunction

	assign raw[0] = item_q.idx_a;
	assign raw[1] = item_q.idx_b;
	assign raw[2] = item_q.idx_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qt[i] = 31'(raw[i]) * 31'(RECIP);
			qm[i] = 27'(qest_q[i]) * 27'(MAX_VERTICES);
			rr[i] = raw[i] - qm[i][9:0];
			rm[i] = (18'(rr[i]) >= 18'(MAX_VERTICES)) ? rr[i] - 10'(MAX_VERTICES) : rr[i];
			pa[i] = pa_q[32*i +: 32];
			pb[i] = pb_q[32*i +: 32];
			pc[i] = pos_rdata[32*i +: 32];
			d1[i] = 33'(pb[i]) - 33'(pa[i]);
			d2[i] = 33'(pc[i]) - 33'(pa[i]);
			h1[i] = $signed(d1[i] + {32'b0, d1[i][32]}) >>> 1;
			h2[i] = $signed(d2[i] + {32'b0, d2[i][32]}) >>> 1;
			sum_in[i]  = nrm_rdata[32*i +: 32];
			sum_ext[i] = 34'(sum_in[i]) + 34'(u[i]);
			if (sum_ext[i] > 34'sh07FFFFFFF) begin
				sum_sat[i] = 32'sh7FFFFFFF;
			end else if (sum_ext[i] < -34'sh080000000) begin
				sum_sat[i] = -32'sh80000000;
			end else begin
				sum_sat[i] = sum_ext[i][31:0];
			end
		end
	end

	always_comb begin
		case (cnt_q)
			3'd0:    begin mul_a = e1_q[1]; mul_b = e2_q[2]; end
			3'd1:    begin mul_a = e1_q[2]; mul_b = e2_q[1]; end
			3'd2:    begin mul_a = e1_q[2]; mul_b = e2_q[0]; end
			3'd3:    begin mul_a = e1_q[0]; mul_b = e2_q[2]; end
			3'd4:    begin mul_a = e1_q[0]; mul_b = e2_q[1]; end
			default: begin mul_a = e1_q[1]; mul_b = e2_q[0]; end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		norm_start = (state_q == S_CROSS) || (state_q == S_RD_WAIT);
		for (int i = 0; i < 3; i++) begin
			if (state_q == S_RD_WAIT) begin
				vin[i] = 64'(sum_in[i]);
			end else begin
				vin[i] = prod_q[2*i] - prod_q[2*i+1];
			end
		end
	end

	always_comb begin
		case (state_q)
			S_RB:    pos_raddr = idx_q[1];
			S_RC:    pos_raddr = idx_q[2];
			default: pos_raddr = idx_q[0];
		endcase
		nrm_raddr = (state_q == S_URD) ? idx_q[k_q] : idx_q[0];
		pos_we    = (state_q == S_LOAD);
		nrm_we    = (state_q == S_LOAD) || (state_q == S_UWR);
		nrm_waddr = (state_q == S_LOAD) ? idx_q[0] : idx_q[k_q];
		if (state_q == S_LOAD) begin
			nrm_wdata = {item_q.init_nz, item_q.init_ny, item_q.init_nx};
		end else begin
			nrm_wdata = {sum_sat[2], sum_sat[1], sum_sat[0]};
		end
	end

	assign q_pop    = (state_q == S_IDLE) && q_valid;
	assign out_free = !m_tvalid_q || m_tready;

	avn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (idx_q[0]),
		.wdata ({item_q.pos_z, item_q.pos_y, item_q.pos_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	avn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_nrm_ram (
		.clk   (clk),
		.we    (nrm_we),
		.waddr (nrm_waddr),
		.wdata (nrm_wdata),
		.raddr (nrm_raddr),
		.rdata (nrm_rdata)
	);

	avn_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vin    (vin),
		.u      (u),
		.stat   (nstat)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					item_q <= q_item;
				end
			end
			S_MOD1: begin
				for (int i = 0; i < 3; i++) qest_q[i] <= qt[i][29:20];
			end
			S_MOD2: begin
				for (int i = 0; i < 3; i++) idx_q[i] <= IW'(rm[i]);
			end
			S_RB: pa_q <= pos_rdata;
			S_RC: pb_q <= pos_rdata;
			S_EDGE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= h1[i][31:0];
					e2_q[i] <= h2[i][31:0];
				end
			end
			S_MUL: prod_q[cnt_q] <= mul_p;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			m_tdata_q <= {2'b00, OUT_18(u[2]), OUT_18(u[1]), OUT_18(u[0])};
			m_tuser_q <= nstat.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= ((state_q == S_OUT) && out_free) || (m_tvalid_q && !m_tready);
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_MOD1;
					end
				end
				S_MOD1: state_q <= S_MOD2;
				S_MOD2: begin
					unique case (item_q.op)
						avn_pkg::OP_LOAD: state_q <= S_LOAD;
						avn_pkg::OP_TRI:  state_q <= S_RA;
						avn_pkg::OP_READ: state_q <= S_RD;
						default:          state_q <= S_IDLE;
					endcase
				end
				S_LOAD:    state_q <= S_IDLE;
				S_RD:      state_q <= S_RD_WAIT;
				S_RD_WAIT: state_q <= S_NWAIT_RD;
				S_NWAIT_RD: begin
					if (nstat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RA:   state_q <= S_RB;
				S_RB:   state_q <= S_RC;
				S_RC:   state_q <= S_EDGE;
				S_EDGE: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == 3'd5) begin
						state_q <= S_CROSS;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_CROSS: state_q <= S_NWAIT_TRI;
				S_NWAIT_TRI: begin
					if (nstat.done) begin
						k_q     <= '0;
						state_q <= S_URD;
					end
				end
				S_URD: state_q <= S_UWR;
				S_UWR: begin
					if (k_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_URD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

>>> rtl/average_vertex_normals.sv
// ----------------------------------------------------------------------------
// average_vertex_normals
// Smooth-shading normal builder: loads vertices, accumulates unit face
// normals of triangles into the vertices, and returns unit vertex normals.
// ----------------------------------------------------------------------------
// Items are executed one at a time; a two-entry queue decouples input from execution.
// A load does not use the normalizer; a read or a triangle passes through its shift,
// 31-step square root and FRAC_BITS+1-step divide, which a zero sum or a degenerate
// triangle skips.
// Reset clears the control state only; the vertex memories are not cleared.
module average_vertex_normals #(
	parameter int MAX_VERTICES = avn_pkg::MAX_VERTICES_DEF,
	parameter int FRAC_BITS    = avn_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// index_a, index_b, index_c, pos_x, pos_y, pos_z, init_nx, init_ny, init_nz, zeros
	input  logic [avn_pkg::S_TDATA_W-1:0] s_tdata,
	// func
	input  logic [avn_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_nx, out_ny, out_nz, zeros
	output logic [avn_pkg::M_TDATA_W-1:0] m_tdata,
	// zero_length
	output logic [avn_pkg::M_TUSER_W-1:0] m_tuser
);

	logic               q_valid;
	logic               q_pop;
	avn_pkg::avn_item_t q_item;

	avn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	avn_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.FRAC_BITS    (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/avn_checker.sv
// ----------------------------------------------------------------------------
// avn_checker
// Port-level checks of the vertex normal averaging block.
// ----------------------------------------------------------------------------
module avn_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [avn_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [avn_pkg::M_TUSER_W-1:0] m_tuser
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_zero_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("zero-length item carries a nonzero normal");

	a_nonzero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[53:0] != '0)
		else $error("unit normal is all zero without the flag");

endmodule

bind average_vertex_normals avn_checker u_avn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
